[design/selectable_fifo_lifo_buffer_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the selectable FIFO/LIFO buffer
// Clocked, reset-qualified property wrappers used by the checker.
// ---------------------------------------------------------------------------
`ifndef SELECTABLE_FIFO_LIFO_BUFFER_MACROS_SVH
`define SELECTABLE_FIFO_LIFO_BUFFER_MACROS_SVH

// same-cycle implication
`define SFLB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sflb assertion failed");

// next-cycle implication
`define SFLB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sflb assertion failed");

`endif

[design/sflb_pkg.sv]
// ---------------------------------------------------------------------------
// sflb_pkg
// Shared types and constants for the selectable FIFO/LIFO buffer.
// ---------------------------------------------------------------------------
package sflb_pkg;

    localparam int SFLB_DEPTH  = 16;
    localparam int SFLB_WORD_W = 32;
    localparam int SFLB_CNT_W  = $clog2(SFLB_DEPTH + 1);

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    typedef enum logic {
        MODE_QUEUE = 1'b0,
        MODE_STACK = 1'b1
    } t_mode;

endpackage

[design/sflb_cmd_if.sv]
// ---------------------------------------------------------------------------
// sflb_cmd_if
// Command channel: insert or remove, with the word to insert.
// ---------------------------------------------------------------------------
interface sflb_cmd_if
    import sflb_pkg::*;
();
    logic                           valid;
    logic                           ready;
    t_cmd                           command;
    logic signed [SFLB_WORD_W-1:0]  value_in;

    modport source (output valid, output command, output value_in, input ready);
    modport sink   (input valid, input command, input value_in, output ready);
endinterface

[design/sflb_rsp_if.sv]
// ---------------------------------------------------------------------------
// sflb_rsp_if
// Result channel: status, removed word and entry count.
// ---------------------------------------------------------------------------
interface sflb_rsp_if
    import sflb_pkg::*;
#(
    parameter int CNT_W = SFLB_CNT_W
) ();
    logic                           valid;
    logic                           ready;
    logic                           ok;
    logic signed [SFLB_WORD_W-1:0]  value_out;
    logic        [CNT_W-1:0]        entry_count;

    modport source (output valid, output ok, output value_out, output entry_count,
                    input ready);
    modport sink   (input valid, input ok, input value_out, input entry_count,
                    output ready);
endinterface

[design/sflb_cfg_if.sv]
// ---------------------------------------------------------------------------
// sflb_cfg_if
// Configuration write channel carrying the removal order.
// ---------------------------------------------------------------------------
interface sflb_cfg_if
    import sflb_pkg::*;
();
    logic   valid;
    logic   ready;
    t_mode  order_mode;

    modport source (output valid, output order_mode, input ready);
    modport sink   (input valid, input order_mode, output ready);
endinterface

[design/sflb_ram.sv]
// ---------------------------------------------------------------------------
// sflb_ram
// Entry store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module sflb_ram
    import sflb_pkg::*;
#(
    parameter int DEPTH  = SFLB_DEPTH,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                    i_clk,
    input  logic                    i_wr_en,
    input  logic [ADDR_W-1:0]       i_wr_addr,
    input  logic [SFLB_WORD_W-1:0]  i_wr_data,
    input  logic                    i_rd_en,
    input  logic [ADDR_W-1:0]       i_rd_addr,
    output logic [SFLB_WORD_W-1:0]  o_rd_data
);

    logic [SFLB_WORD_W-1:0] r_mem [DEPTH];
    logic [SFLB_WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/selectable_fifo_lifo_buffer.sv]
// ---------------------------------------------------------------------------
// selectable_fifo_lifo_buffer
// Bounded ring of signed words, removed oldest-first or newest-first.
// ---------------------------------------------------------------------------
// One command transaction is taken per cycle, and its result is presented on
// the cycle after acceptance; the removed word comes from the registered
// read port of the entry store. Pointers and the count live in flip-flops and
// are updated at acceptance, so a removal straight after an insert reads the
// word already written. A stalled result holds the command side only when the
// output register is full and not being taken. The store is not cleared after
// reset; no entry is read before it is written. The mode register may be
// written only while the buffer is idle.
module selectable_fifo_lifo_buffer
    import sflb_pkg::*;
#(
    parameter int DEPTH = SFLB_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sflb_cmd_if.sink    i_cmd,
    sflb_rsp_if.source  o_rsp,
    sflb_cfg_if.sink    i_cfg
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_mode              r_mode;
    logic [PTR_W-1:0]   r_oldest, n_oldest;
    logic [PTR_W-1:0]   r_newest, n_newest;
    logic [CNT_W-1:0]   r_count,  n_count;
    logic               r_out_valid, n_out_valid;
    logic               r_ok;
    logic               r_rm;
    logic [CNT_W-1:0]   r_cnt_out;

    logic               accept;
    logic               do_ins, do_rm;
    logic [PTR_W-1:0]   newest_next, newest_prev, oldest_next;
    logic [PTR_W-1:0]   rd_addr;
    logic [SFLB_WORD_W-1:0] rd_data;

    assign i_cfg.ready = i_rst_n;
    assign i_cmd.ready = i_rst_n && (!r_out_valid || o_rsp.ready);
    assign accept      = i_cmd.valid && i_cmd.ready;

    assign do_ins = accept && (i_cmd.command == CMD_INSERT) && (r_count != FULL_CNT);
    assign do_rm  = accept && (i_cmd.command == CMD_REMOVE) && (r_count != '0);

    assign newest_next = (r_newest == LAST_PTR) ? '0 : r_newest + 1'b1;
    assign newest_prev = (r_newest == '0) ? LAST_PTR : r_newest - 1'b1;
    assign oldest_next = (r_oldest == LAST_PTR) ? '0 : r_oldest + 1'b1;
    assign rd_addr     = (r_mode == MODE_STACK) ? newest_prev : r_oldest;

    always_comb begin
        n_oldest    = r_oldest;
        n_newest    = r_newest;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
        if (accept) begin
            n_out_valid = 1'b1;
        end
        if (do_ins) begin
            n_newest = newest_next;
            n_count  = r_count + 1'b1;
        end else if (do_rm) begin
            n_count = r_count - 1'b1;
            if (r_mode == MODE_STACK) begin
                n_newest = newest_prev;
            end else begin
                n_oldest = oldest_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_QUEUE;
            r_oldest    <= '0;
            r_newest    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_mode <= i_cfg.order_mode;
            end
            r_oldest    <= n_oldest;
            r_newest    <= n_newest;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ok      <= do_ins || do_rm;
            r_rm      <= do_rm;
            r_cnt_out <= n_count;
        end
    end

    sflb_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (PTR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (do_ins),
        .i_wr_addr (r_newest),
        .i_wr_data (i_cmd.value_in),
        .i_rd_en   (do_rm),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.ok          = r_ok;
    assign o_rsp.value_out   = r_rm ? $signed(rd_data) : '0;
    assign o_rsp.entry_count = r_cnt_out;

endmodule

[design/sflb_checker.sv]
// ---------------------------------------------------------------------------
// sflb_checker
// Port-level checks on the buffer's result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "selectable_fifo_lifo_buffer_macros.svh"

module sflb_checker
    import sflb_pkg::*;
#(
    parameter int DEPTH = SFLB_DEPTH,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cmd_valid,
    input  logic                    i_cmd_ready,
    input  logic                    i_rsp_valid,
    input  logic                    i_rsp_ready,
    input  logic                    i_rsp_ok,
    input  logic [SFLB_WORD_W-1:0]  i_rsp_value,
    input  logic [CNT_W-1:0]        i_rsp_count
);

    logic                           rsp_stall;
    logic [SFLB_WORD_W+CNT_W:0]     rsp_bus;

    assign rsp_stall = i_rsp_valid && !i_rsp_ready;
    assign rsp_bus   = {i_rsp_ok, i_rsp_value, i_rsp_count};

    // every accepted command yields a result on the next cycle
    `SFLB_ASSERT_NXT(a_result_follows, i_clk, i_rst_n, i_cmd_valid && i_cmd_ready, i_rsp_valid)

    // a refused or failed command carries no word
    `SFLB_ASSERT_IMP(a_fail_zero, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ok, i_rsp_value == '0)

    `SFLB_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, i_rsp_valid, i_rsp_count <= CNT_W'(DEPTH))

    `SFLB_ASSERT_NXT(a_rsp_hold, i_clk, i_rst_n, rsp_stall, i_rsp_valid && $stable(rsp_bus))

endmodule

bind selectable_fifo_lifo_buffer sflb_checker #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
) u_sflb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cmd_valid (i_cmd.valid),
    .i_cmd_ready (i_cmd.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_ok    (o_rsp.ok),
    .i_rsp_value (o_rsp.value_out),
    .i_rsp_count (o_rsp.entry_count)
);

[sim/selectable_fifo_lifo_buffer_test.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// selectable_fifo_lifo_buffer_test
// Self-checking bench for the selectable FIFO/LIFO buffer. A ring tracker
// follows every accepted command and predicts ok, removed word and entry
// count, which are compared with each result transaction in order. Directed
// extremes come first, then random phases biased towards filling, draining
// or mixing, with the removal order switched between phases while entries
// are held, and with random gaps and stalls on both channels.
// ---------------------------------------------------------------------------
module selectable_fifo_lifo_buffer_test;
    import sflb_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 600;

    class ring_tracker;
        typedef struct packed {
            logic                          ok;
            logic signed [SFLB_WORD_W-1:0] word;
            logic        [SFLB_CNT_W-1:0]  count;
        } t_result;

        logic signed [SFLB_WORD_W-1:0] slots [SFLB_DEPTH];
        int unsigned head;
        int unsigned tail;
        int unsigned held;
        t_mode       mode;
        t_result     due[$];
        int          mismatches;
        int          checked;
        int          full_refusals;
        int          empty_refusals;
        int          queue_pops;
        int          stack_pops;
        int          peak_held;

        function new();
            head = 0;
            tail = 0;
            held = 0;
            mode = MODE_QUEUE;
        endfunction

        function void set_mode(t_mode m);
            mode = m;
        endfunction

        function void note_command(t_cmd c, logic signed [SFLB_WORD_W-1:0] v);
            t_result r;
            r = '0;
            if (c == CMD_INSERT) begin
                if (held < SFLB_DEPTH) begin
                    slots[tail] = v;
                    tail = (tail + 1) % SFLB_DEPTH;
                    held++;
                    r.ok = 1'b1;
                end else begin
                    full_refusals++;
                end
            end else if (held != 0) begin
                if (mode == MODE_QUEUE) begin
                    r.word = slots[head];
                    head = (head + 1) % SFLB_DEPTH;
                    queue_pops++;
                end else begin
                    tail = (tail + SFLB_DEPTH - 1) % SFLB_DEPTH;
                    r.word = slots[tail];
                    stack_pops++;
                end
                held--;
                r.ok = 1'b1;
            end else begin
                empty_refusals++;
            end
            if (held > peak_held)
                peak_held = held;
            r.count = SFLB_CNT_W'(held);
            due.push_back(r);
        endfunction

        function void flag_mismatch(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s", $time, msg);
        endfunction

        function void check_result(logic ok, logic signed [SFLB_WORD_W-1:0] word,
                                   logic [SFLB_CNT_W-1:0] count);
            t_result want;
            checked++;
            if (due.size() == 0) begin
                flag_mismatch($sformatf("unexpected result ok=%0b value=%0d count=%0d",
                                        ok, word, count));
                return;
            end
            want = due.pop_front();
            if (ok !== want.ok || word !== want.word || count !== want.count)
                flag_mismatch($sformatf(
                    "expected ok=%0b value=%0d count=%0d, got ok=%0b value=%0d count=%0d",
                    want.ok, want.word, want.count, ok, word, count));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycles;
    int   commands_sent;
    int   mode_writes;
    int   src_gap_max;
    int   snk_gap_max;
    int   hold_cycles;

    ring_tracker tracker = new();

    sflb_cmd_if cmd_ch ();
    sflb_rsp_if rsp_ch ();
    sflb_cfg_if cfg_ch ();

    selectable_fifo_lifo_buffer dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side: random stall per transaction, long hold when requested
    initial begin
        int stall;
        rsp_ch.ready = 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            stall = $urandom_range(snk_gap_max, 0);
            if (hold_cycles > 0) begin
                stall = hold_cycles;
                hold_cycles = 0;
            end
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid) @(posedge clk);
            tracker.check_result(rsp_ch.ok, rsp_ch.value_out, rsp_ch.entry_count);
        end
    end

    task automatic send_cmd(t_cmd c, logic signed [SFLB_WORD_W-1:0] v);
        int gap;
        gap = $urandom_range(src_gap_max, 0);
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.command  <= c;
        cmd_ch.value_in <= v;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        tracker.note_command(c, v);
        commands_sent++;
    endtask

    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        while (tracker.due.size() != 0) @(posedge clk);
    endtask

    // only called once the command side is idle and all results are in
    task automatic write_mode(t_mode m);
        cmd_ch.valid     <= 1'b0;
        cfg_ch.valid     <= 1'b1;
        cfg_ch.order_mode <= m;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        tracker.set_mode(m);
        mode_writes++;
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [SFLB_WORD_W-1:0] pick_word();
        case ($urandom_range(11, 0))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int   phase;
        int   phase_len;
        int   insert_pct;
        int   random_sent;
        t_cmd c;

        rst_n            = 1'b0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.command   = CMD_INSERT;
        cmd_ch.value_in  = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.order_mode = MODE_QUEUE;
        src_gap_max      = 0;
        snk_gap_max      = 0;
        hold_cycles      = 0;
        commands_sent    = 0;
        mode_writes      = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty removal, extreme words, queue then stack order
        write_mode(MODE_QUEUE);
        send_cmd(CMD_REMOVE, 32'h1234_5678);
        send_cmd(CMD_INSERT, 32'h7FFF_FFFF);
        send_cmd(CMD_INSERT, 32'h8000_0000);
        send_cmd(CMD_INSERT, 32'hFFFF_FFFF);
        send_cmd(CMD_INSERT, 32'h0000_0000);
        send_cmd(CMD_INSERT, 32'h5555_5555);
        send_cmd(CMD_INSERT, 32'hAAAA_AAAA);
        send_cmd(CMD_REMOVE, 32'hFFFF_FFFF);
        send_cmd(CMD_REMOVE, 32'h0000_0000);
        wait_drained();
        write_mode(MODE_STACK);
        send_cmd(CMD_REMOVE, '0);
        send_cmd(CMD_REMOVE, '0);
        send_cmd(CMD_INSERT, 32'sd1);
        send_cmd(CMD_REMOVE, '0);
        send_cmd(CMD_REMOVE, '0);
        send_cmd(CMD_REMOVE, '0);
        send_cmd(CMD_REMOVE, '0);
        wait_drained();

        // random phases: fill-heavy, drain-heavy and mixed traffic
        random_sent = 0;
        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            wait_drained();
            write_mode(t_mode'(phase % 2));
            case (phase % 3)
                0: insert_pct = 85;
                1: insert_pct = 20;
                default: insert_pct = 50;
            endcase
            src_gap_max = ($urandom_range(3, 0) == 0) ? 0 : 4;
            snk_gap_max = ($urandom_range(3, 0) == 0) ? 0 : 4;
            if (phase == 2 || phase == 7)
                hold_cycles = 40;
            phase_len = $urandom_range(60, 30);
            repeat (phase_len) begin
                c = ($urandom_range(99, 0) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
                send_cmd(c, pick_word());
                random_sent++;
                if ($urandom_range(49, 0) == 0)
                    wait_drained();
            end
            phase++;
        end

        wait_drained();
        repeat (8) @(posedge clk);

        $display("Covered %0d commands over %0d mode writes; %0d results checked, peak fill %0d.",
                 commands_sent, mode_writes, tracker.checked, tracker.peak_held);
        $display("Queue removals %0d, stack removals %0d, full refusals %0d, empty refusals %0d.",
                 tracker.queue_pops, tracker.stack_pops, tracker.full_refusals,
                 tracker.empty_refusals);
        if (tracker.mismatches == 0 && tracker.due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d results outstanding",
                     tracker.mismatches, tracker.due.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
